### src/hss_pkg.sv
`timescale 1ns / 1ps
// Package for the half-step stepper sequencer: request codes, item and motor
// state types, and the phase table and coil nibble placement functions.
// No dependencies.
package hss_pkg;

    localparam int STEP_W  = 24;
    localparam int WAIT_W  = 24;
    localparam int BATCH_W = 8;
    localparam int PRESC_W = 8;
    localparam int OFF_W   = 3;
    localparam int NUM_CFG = 2;

    localparam logic [OFF_W-1:0] OFFSET0_RESET = 3'd0;
    localparam logic [OFF_W-1:0] OFFSET1_RESET = 3'd4;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_TURN     = 3'd1,
        REQ_PAUSE    = 3'd2,
        REQ_RESUME   = 3'd3,
        REQ_STOP     = 3'd4,
        REQ_SET_WAIT = 3'd5
    } req_e;

    typedef struct packed {
        logic [2:0]        req_type;
        logic              motor_index;
        logic [STEP_W-1:0] step_count;
        logic              direction;
        logic [WAIT_W-1:0] wait_ticks;
    } item_t;

    typedef struct packed {
        logic [7:0]        coil_byte;
        logic              latch_update;
        logic              ticking;
        logic              all_ready;
        logic [STEP_W-1:0] steps_left;
    } result_t;

    typedef struct packed {
        logic [STEP_W-1:0]  steps;
        logic [BATCH_W-1:0] batch;
        logic [WAIT_W-1:0]  wait_rem;
        logic [WAIT_W-1:0]  wait_set;
        logic [PRESC_W-1:0] presc;
        logic [3:0]         phase;
        logic               paused;
        logic               dir;
    } motor_t;

    // Left rotation of a byte by 0 to 7 places.
    function automatic logic [7:0] rot8(logic [7:0] v, logic [OFF_W-1:0] amt);
        logic [15:0] d;
        d = {v, v} << amt;
        return d[15:8];
    endfunction

    // Replaces one motor's nibble in the shared coil byte.
    function automatic logic [7:0] put_phase(logic [7:0] cur, logic [3:0] pat,
                                             logic [OFF_W-1:0] off);
        logic [7:0] mask;
        mask = rot8(8'h0F, off);
        return (cur & ~mask) | rot8({4'b0000, pat}, off);
    endfunction

    // Half-step sequence 3,2,6,4,C,8,9,1 forward; the idle pattern enters at 3
    // going forward and at 9 going backward.
    function automatic logic [3:0] next_phase(logic [3:0] pat, logic backward);
        logic [3:0] f;
        logic [3:0] b;
        case (pat)
            4'h0:    begin f = 4'h3; b = 4'h9; end
            4'h1:    begin f = 4'h3; b = 4'h9; end
            4'h2:    begin f = 4'h6; b = 4'h3; end
            4'h3:    begin f = 4'h2; b = 4'h1; end
            4'h4:    begin f = 4'hC; b = 4'h6; end
            4'h6:    begin f = 4'h4; b = 4'h2; end
            4'h8:    begin f = 4'h9; b = 4'hC; end
            4'h9:    begin f = 4'h1; b = 4'h8; end
            4'hC:    begin f = 4'h8; b = 4'h4; end
            default: begin f = 4'h0; b = 4'h0; end
        endcase
        return backward ? b : f;
    endfunction

endpackage

### src/hss_motor_tick.sv
`timescale 1ns / 1ps
// One motor's work on a tick: prescaler, phase advance, batch and wait
// counting, and coil release. Combinational. Depends on hss_pkg.
module hss_motor_tick #(
    parameter int PRESCALE  = 4,
    parameter int BATCH_LEN = 8
) (
    input  hss_pkg::motor_t                cur,
    input  logic [hss_pkg::OFF_W-1:0]      offset,
    input  logic                           others_ready,
    input  logic [7:0]                     byte_in,
    output hss_pkg::motor_t                nxt,
    output logic [7:0]                     byte_out,
    output logic                           released
);

    logic [hss_pkg::PRESC_W-1:0] presc_dec;
    logic [hss_pkg::BATCH_W-1:0] batch_after;
    logic [hss_pkg::BATCH_W-1:0] batch_load;
    logic                        run;
    logic                        stepped;
    logic                        finish;

    assign presc_dec = cur.presc - 8'd1;
    assign stepped   = run && (presc_dec == '0);
    assign batch_load = (cur.steps < 24'(BATCH_LEN)) ? cur.steps[7:0] : 8'(BATCH_LEN);

    always_comb
    begin
        run    = 1'b0;
        finish = 1'b0;
        if (cur.wait_set != '0)
        begin
            if (cur.batch != '0)
            begin
                run = (cur.steps != '0) && !cur.paused;
            end
            else if (cur.wait_rem == '0)
            begin
                finish = 1'b1;
            end
        end
        else if ((cur.steps != '0) && !cur.paused)
        begin
            run = 1'b1;
        end
        else
        begin
            finish = 1'b1;
        end
    end

    always_comb
    begin
        nxt         = cur;
        byte_out    = byte_in;
        released    = 1'b0;
        batch_after = stepped ? cur.batch - 8'd1 : cur.batch;

        if (run)
        begin
            nxt.presc = presc_dec;
        end
        if (stepped)
        begin
            nxt.presc = 8'(PRESCALE);
            nxt.steps = cur.steps - 24'd1;
            nxt.phase = hss_pkg::next_phase(cur.phase, cur.dir);
            byte_out  = hss_pkg::put_phase(byte_in, nxt.phase, offset);
        end

        if (cur.wait_set != '0)
        begin
            if (cur.batch != '0)
            begin
                nxt.batch = batch_after;
                if (batch_after == '0)
                begin
                    nxt.wait_rem = cur.wait_set;
                end
            end
            else if (cur.wait_rem != '0)
            begin
                nxt.wait_rem = cur.wait_rem - 24'd1;
                if (cur.wait_rem == 24'd1)
                begin
                    nxt.batch = batch_load;
                end
            end
        end

        if (finish)
        begin
            nxt.wait_set = '0;
            // Coils are released only when no motor has steps or wait left.
            if (others_ready && (cur.steps == '0) && (cur.wait_rem == '0))
            begin
                nxt.phase = 4'h0;
                byte_out  = hss_pkg::put_phase(byte_in, 4'h0, offset);
                released  = 1'b1;
            end
        end
    end

endmodule

### src/hss_core.sv
`timescale 1ns / 1ps
// Motor state registers, request decoding and the tick chain across motors.
// Depends on hss_pkg and hss_motor_tick.
module hss_core #(
    parameter int NUM_MOTORS = 2,
    parameter int PRESCALE   = 4,
    parameter int BATCH_LEN  = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        adv,
    input  hss_pkg::item_t                              item,
    input  logic [hss_pkg::NUM_CFG-1:0][hss_pkg::OFF_W-1:0] offsets,
    output hss_pkg::result_t                            result
);

    localparam hss_pkg::motor_t MOTOR_RESET = '{
        steps:    '0,
        batch:    '0,
        wait_rem: '0,
        wait_set: '0,
        presc:    8'(PRESCALE),
        phase:    4'h0,
        paused:   1'b0,
        dir:      1'b0
    };

    hss_pkg::motor_t st_reg   [NUM_MOTORS];
    hss_pkg::motor_t st_next  [NUM_MOTORS];
    hss_pkg::motor_t tick_st  [NUM_MOTORS];
    logic [7:0]      byte_chain [NUM_MOTORS+1];
    logic [NUM_MOTORS-1:0] released;
    logic [NUM_MOTORS-1:0] others_ready;
    logic [NUM_MOTORS-1:0] ready_old;
    logic [NUM_MOTORS-1:0] ready_new;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [7:0] sent_reg;
    logic [7:0] sent_next;
    logic [7:0] sent_tick;
    logic       sent_now_tick;
    logic       sent_now;
    logic       tick_en_reg;
    logic       tick_en_next;
    logic [hss_pkg::BATCH_W-1:0] turn_batch;

    assign byte_chain[0] = byte_reg;
    assign turn_batch = (item.step_count < 24'(BATCH_LEN)) ? item.step_count[7:0]
                                                           : 8'(BATCH_LEN);

    genvar g;
    generate
        for (g = 0; g < NUM_MOTORS; g++)
        begin : g_motor
            assign ready_old[g] = (st_reg[g].steps == '0) && (st_reg[g].wait_rem == '0);
            assign ready_new[g] = (tick_st[g].steps == '0) && (tick_st[g].wait_rem == '0);

            // Motors are ticked in order: earlier ones are seen already updated.
            always_comb
            begin
                others_ready[g] = 1'b1;
                for (int j = 0; j < NUM_MOTORS; j++)
                begin
                    if (j < g)
                    begin
                        others_ready[g] = others_ready[g] & ready_new[j];
                    end
                    else if (j > g)
                    begin
                        others_ready[g] = others_ready[g] & ready_old[j];
                    end
                end
            end

            hss_motor_tick #(
                .PRESCALE  (PRESCALE),
                .BATCH_LEN (BATCH_LEN)
            ) u_tick (
                .cur          (st_reg[g]),
                .offset       (offsets[g]),
                .others_ready (others_ready[g]),
                .byte_in      (byte_chain[g]),
                .nxt          (tick_st[g]),
                .byte_out     (byte_chain[g+1]),
                .released     (released[g])
            );
        end
    endgenerate

    // A release sends its byte at once; the last byte is sent if it differs.
    always_comb
    begin
        sent_tick     = sent_reg;
        sent_now_tick = 1'b0;
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            if (released[k] && (byte_chain[k+1] != sent_tick))
            begin
                sent_tick     = byte_chain[k+1];
                sent_now_tick = 1'b1;
            end
        end
        if (byte_chain[NUM_MOTORS] != sent_tick)
        begin
            sent_tick     = byte_chain[NUM_MOTORS];
            sent_now_tick = 1'b1;
        end
    end

    always_comb
    begin
        st_next      = st_reg;
        byte_next    = byte_reg;
        sent_next    = sent_reg;
        tick_en_next = tick_en_reg;
        sent_now     = 1'b0;
        if (item.req_type == hss_pkg::REQ_TICK)
        begin
            if (tick_en_reg)
            begin
                st_next   = tick_st;
                byte_next = byte_chain[NUM_MOTORS];
                sent_next = sent_tick;
                sent_now  = sent_now_tick;
                if (|released)
                begin
                    tick_en_next = 1'b0;
                end
            end
        end
        else
        begin
            for (int k = 0; k < NUM_MOTORS; k++)
            begin
                if (item.motor_index == 1'(k))
                begin
                    unique case (hss_pkg::req_e'(item.req_type))
                        hss_pkg::REQ_TURN:
                        begin
                            st_next[k].steps = item.step_count;
                            if (st_reg[k].wait_set != '0)
                            begin
                                st_next[k].batch = turn_batch;
                            end
                            st_next[k].dir = item.direction;
                            tick_en_next   = 1'b1;
                        end
                        hss_pkg::REQ_PAUSE:  st_next[k].paused = 1'b1;
                        hss_pkg::REQ_RESUME: st_next[k].paused = 1'b0;
                        hss_pkg::REQ_STOP:
                        begin
                            st_next[k].steps    = '0;
                            st_next[k].wait_rem = '0;
                            st_next[k].wait_set = '0;
                            st_next[k].presc    = 8'(PRESCALE);
                        end
                        hss_pkg::REQ_SET_WAIT: st_next[k].wait_set = item.wait_ticks;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        result.coil_byte    = byte_next;
        result.latch_update = sent_now;
        result.ticking      = tick_en_next;
        result.all_ready    = 1'b1;
        result.steps_left   = '0;
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            if ((st_next[k].steps != '0) || (st_next[k].wait_rem != '0))
            begin
                result.all_ready = 1'b0;
            end
            if (item.motor_index == 1'(k))
            begin
                result.steps_left = st_next[k].steps;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_MOTORS; k++)
            begin
                st_reg[k] <= MOTOR_RESET;
            end
            byte_reg    <= '0;
            sent_reg    <= '0;
            tick_en_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_reg      <= st_next;
            byte_reg    <= byte_next;
            sent_reg    <= sent_next;
            tick_en_reg <= tick_en_next;
        end
    end

endmodule

### src/stepper_half_step_sequencer.sv
`timescale 1ns / 1ps
// Half-step sequencer for up to two four-coil stepper motors sharing one
// coil byte. Top level. Depends on hss_pkg and hss_core.
//
// Usage: one request per item on the in_valid/in_ready channel (tick, turn,
// pause, resume, stop, set wait). Each request gives exactly one result on
// out_valid/out_ready: the coil byte, a latch-update flag, the ticking flag,
// the all-ready flag and the addressed motor's remaining steps.
// The offset registers are written on cfg_valid/cfg_ready, which is always
// ready; write them only while no request is in flight.
// A request passes through the input register and then the result register,
// and out_valid rises when the result register is loaded. A request is accepted every
// cycle while results are taken; the whole request is decoded and both motors
// are ticked in one pass between those two registers.
// When the receiver stalls, the result is held and one further request waits
// in the input register, after which in_ready falls.
// Reset clears all motor state, loads the prescalers, sets offsets to 0 and 4
// and empties both registers.
module stepper_half_step_sequencer #(
    parameter int NUM_MOTORS = 2,
    parameter int PRESCALE   = 4,
    parameter int BATCH_LEN  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic        motor_index,
    input  logic [23:0] step_count,
    input  logic        direction,
    input  logic [23:0] wait_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  coil_byte,
    output logic        latch_update,
    output logic        ticking,
    output logic        all_ready,
    output logic [23:0] steps_left,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data
);

    logic [hss_pkg::NUM_CFG-1:0][hss_pkg::OFF_W-1:0] offset_reg;
    logic             s1_valid_reg;
    hss_pkg::item_t   s1_item_reg;
    logic             out_valid_reg;
    hss_pkg::result_t out_reg;
    hss_pkg::result_t result;
    logic             adv;

    assign cfg_ready = 1'b1;
    assign adv       = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg[0] <= hss_pkg::OFFSET0_RESET;
            offset_reg[1] <= hss_pkg::OFFSET1_RESET;
        end
        else if (cfg_valid)
        begin
            offset_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.req_type    <= req_type;
            s1_item_reg.motor_index <= motor_index;
            s1_item_reg.step_count  <= step_count;
            s1_item_reg.direction   <= direction;
            s1_item_reg.wait_ticks  <= wait_ticks;
        end
        if (adv)
        begin
            out_reg <= result;
        end
    end

    hss_core #(
        .NUM_MOTORS (NUM_MOTORS),
        .PRESCALE   (PRESCALE),
        .BATCH_LEN  (BATCH_LEN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .item    (s1_item_reg),
        .offsets (offset_reg),
        .result  (result)
    );

    assign out_valid    = out_valid_reg;
    assign coil_byte    = out_reg.coil_byte;
    assign latch_update = out_reg.latch_update;
    assign ticking      = out_reg.ticking;
    assign all_ready    = out_reg.all_ready;
    assign steps_left   = out_reg.steps_left;

endmodule

### src/hss_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stepper sequencer, bound to the top level.
// Depends only on the top level's ports.
module hss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  coil_byte,
    input logic        latch_update,
    input logic        ticking,
    input logic        all_ready,
    input logic [23:0] steps_left
);

    logic [7:0] last_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_byte_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_byte_reg <= coil_byte;
        end
    end

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coil_byte)
        && $stable(latch_update) && $stable(ticking) && $stable(all_ready)
        && $stable(steps_left))
        else $error("result changed while stalled");

    // With every motor ready the addressed motor can have no steps left.
    a_ready_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && all_ready |-> steps_left == 24'd0)
        else $error("all_ready with steps left");

    // A byte that differs from the previous result must have been latched.
    a_byte_latched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (coil_byte != last_byte_reg) |-> latch_update)
        else $error("coil byte changed without latch update");

endmodule

bind stepper_half_step_sequencer hss_checker u_hss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .coil_byte    (coil_byte),
    .latch_update (latch_update),
    .ticking      (ticking),
    .all_ready    (all_ready),
    .steps_left   (steps_left)
);
